// File: sv/gri_pkg.sv
// Shared widths, register indexes, stage payload types and helpers for the
// gate resample index/weight block. No dependencies.
package gri_pkg;

    localparam int TGT_W     = 12;
    localparam int CNT_W     = 13;
    localparam int RNG_W     = 32;
    localparam int SP_W      = 31;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_GATES = 4096;

    localparam int GATE_W = 13;
    localparam int WT_W   = 17;
    localparam int IDX_W  = 13;                  // integer quotient bits
    localparam int FRAC_W = 16;                  // fraction quotient bits
    localparam int QUO_W  = IDX_W + FRAC_W;
    localparam int DIV_ST = QUO_W;               // one quotient bit per stage

    localparam int P_W   = TGT_W + SP_W;         // target_gate * new spacing
    localparam int E_W   = P_W + 1;              // shifted dividend, unsigned part
    localparam int DSH_W = RNG_W + 3;            // new_start - old_start + old spacing
    localparam int MUL_W = CNT_W + SP_W;         // count * old spacing
    localparam int RHS_W = MUL_W + 3;            // 2 * num + new spacing

    localparam logic [CFG_IDX_W-1:0] CFG_OLD_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_SP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_SP    = 3'd4;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_GATES);

    typedef struct packed {
        logic far;      // lower gate below -1 or above the quotient range
        logic gir;      // target gate inside the rounded new gate count
        logic remap;
    } t_ctl;

    typedef struct packed {
        t_ctl           ctl;
        logic [E_W-1:0] rem;
    } t_div_in;

    typedef struct packed {
        t_ctl             ctl;
        logic [QUO_W-1:0] quo;
    } t_div_out;

    function automatic logic [SP_W-1:0] sp_fix(input logic [SP_W-1:0] sp);
        return (sp == '0) ? SP_W'(1) : sp;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_clamp(input logic [CNT_W-1:0] c);
        return (c > MAX_COUNT) ? MAX_COUNT : c;
    endfunction

endpackage

// File: sv/gate_resample_index_weight.sv
// Gate resample index/weight: old-geometry gate indices and linear weights per target gate.
// Path from input transfer to output valid: front stages, divider stages, then the output register.
// Throughput: one transfer per cycle while the output is not stalled; the 29-stage restoring divider sets the depth.
// Derived geometry terms are registered from the configuration registers; the count compare term is registered twice.
// Reset (sync, active low) clears all valid bits and loads the default geometry.
// Depends on gri_pkg, gri_front, gri_div, gri_back.
module gate_resample_index_weight import gri_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [TGT_W-1:0]         i_target_gate,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_remap_needed,
    output logic                     o_gate_in_range,
    output logic signed [GATE_W-1:0] o_nearest_gate,
    output logic signed [GATE_W-1:0] o_lower_gate,
    output logic signed [GATE_W-1:0] o_upper_gate,
    output logic [WT_W-1:0]          o_lower_weight,
    output logic [WT_W-1:0]          o_upper_weight
);

    logic [CNT_W-1:0]        r_old_count;
    logic signed [RNG_W-1:0] r_old_start;
    logic [SP_W-1:0]         r_old_sp;
    logic signed [RNG_W-1:0] r_new_start;
    logic [SP_W-1:0]         r_new_sp;

    logic [MUL_W-1:0]        r_cfg_mul;
    logic signed [RNG_W:0]   r_cfg_sdiff;
    logic signed [DSH_W-1:0] r_cfg_dsh;
    logic signed [RHS_W-1:0] r_cfg_rhs;

    logic [SP_W-1:0]         w_g0;
    logic [SP_W-1:0]         w_g1;
    logic [CNT_W-1:0]        w_cnt;
    logic                    w_remap;

    logic [MUL_W-1:0]        n_cfg_mul;
    logic signed [RNG_W:0]   n_cfg_sdiff;
    logic signed [DSH_W-1:0] n_cfg_dsh;
    logic signed [RHS_W-1:0] w_num;
    logic signed [RHS_W-1:0] n_cfg_rhs;

    logic     w_f_valid, w_f_stall;
    t_div_in  w_f_data;
    logic     w_d_valid, w_d_stall;
    t_div_out w_d_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_count <= '0;
            r_old_start <= RNG_W'(32768);
            r_old_sp    <= SP_W'(65536);
            r_new_start <= RNG_W'(32768);
            r_new_sp    <= SP_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OLD_COUNT: r_old_count <= i_cfg_data[CNT_W-1:0];
                CFG_OLD_START: r_old_start <= $signed(i_cfg_data[RNG_W-1:0]);
                CFG_OLD_SP:    r_old_sp    <= i_cfg_data[SP_W-1:0];
                CFG_NEW_START: r_new_start <= $signed(i_cfg_data[RNG_W-1:0]);
                CFG_NEW_SP:    r_new_sp    <= i_cfg_data[SP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_g0    = sp_fix(r_old_sp);
    assign w_g1    = sp_fix(r_new_sp);
    assign w_cnt   = cnt_clamp(r_old_count);
    assign w_remap = !((r_old_start == r_new_start) && (r_old_sp == r_new_sp));

    // newcount check: target < round(num / g1) <=> 2*(target+1)*g1 <= 2*num + g1
    assign n_cfg_mul   = MUL_W'(w_cnt) * MUL_W'(w_g0);
    assign n_cfg_sdiff = (RNG_W + 1)'(r_old_start) - (RNG_W + 1)'(r_new_start);
    assign n_cfg_dsh   = DSH_W'(r_new_start) - DSH_W'(r_old_start) + $signed(DSH_W'(w_g0));
    assign w_num       = RHS_W'(r_cfg_sdiff) + $signed(RHS_W'(r_cfg_mul));
    assign n_cfg_rhs   = $signed({w_num[RHS_W-2:0], 1'b0}) + $signed(RHS_W'(w_g1));

    always_ff @(posedge i_clk) begin
        r_cfg_mul   <= n_cfg_mul;
        r_cfg_sdiff <= n_cfg_sdiff;
        r_cfg_dsh   <= n_cfg_dsh;
        r_cfg_rhs   <= n_cfg_rhs;
    end

    gri_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_target_gate (i_target_gate),
        .i_old_sp      (w_g0),
        .i_new_sp      (w_g1),
        .i_remap       (w_remap),
        .i_dsh         (r_cfg_dsh),
        .i_rhs         (r_cfg_rhs),
        .o_valid       (w_f_valid),
        .i_stall       (w_f_stall),
        .o_data        (w_f_data)
    );

    gri_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_f_valid),
        .o_stall  (w_f_stall),
        .i_data   (w_f_data),
        .i_old_sp (w_g0),
        .o_valid  (w_d_valid),
        .i_stall  (w_d_stall),
        .o_data   (w_d_data)
    );

    gri_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_d_valid),
        .o_stall         (w_d_stall),
        .i_data          (w_d_data),
        .i_count         (w_cnt),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_remap_needed  (o_remap_needed),
        .o_gate_in_range (o_gate_in_range),
        .o_nearest_gate  (o_nearest_gate),
        .o_lower_gate    (o_lower_gate),
        .o_upper_gate    (o_upper_gate),
        .o_lower_weight  (o_lower_weight),
        .o_upper_weight  (o_upper_weight)
    );

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_lower_weight != '0 || o_upper_weight != '0)) |->
        (({1'b0, o_lower_weight} + {1'b0, o_upper_weight}) == 18'd65536))
        else $error("weights do not sum to one");

    a_gate_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_lower_gate != '1 && o_upper_gate != '1) |->
        (o_upper_gate == o_lower_gate + 13'sd1))
        else $error("upper gate not next to lower gate");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    a_remap_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_old_start == r_new_start && r_old_sp == r_new_sp) |->
        !o_remap_needed)
        else $error("remap flagged for equal geometry");

endmodule

// File: sv/gri_front.sv
// Front three stages: target range multiply, offset add, range and count compares.
// Depends on gri_pkg.
module gri_front import gri_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [TGT_W-1:0]        i_target_gate,
    input  logic [SP_W-1:0]         i_old_sp,
    input  logic [SP_W-1:0]         i_new_sp,
    input  logic                    i_remap,
    input  logic signed [DSH_W-1:0] i_dsh,
    input  logic signed [RHS_W-1:0] i_rhs,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_div_in                 o_data
);

    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    logic [P_W-1:0]         r_p1;
    logic                   r_remap1;
    logic signed [E_W:0]    r_e2;
    logic [E_W-1:0]         r_l2;
    logic                   r_remap2;
    t_div_in                r_d3;

    logic [P_W-1:0]         n_p1;
    logic signed [E_W:0]    n_e2;
    logic [E_W-1:0]         n_l2;
    logic [E_W-1:0]         w_lim;
    logic signed [RHS_W-1:0] w_lhs;
    t_div_in                n_d3;

    assign w_en3   = !r_v3 || !i_stall;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;

    assign n_p1 = P_W'(i_target_gate) * P_W'(i_new_sp);

    assign n_e2 = $signed({{(E_W + 1 - P_W){1'b0}}, r_p1}) + (E_W + 1)'(i_dsh);
    assign n_l2 = E_W'(r_p1) + E_W'(i_new_sp);

    // quotient of 2^IDX_W or more cannot land on an old gate
    assign w_lim = {i_old_sp, {IDX_W{1'b0}}};
    assign w_lhs = $signed({{(RHS_W - E_W - 1){1'b0}}, r_l2, 1'b0});

    always_comb begin
        n_d3.ctl.far   = r_e2[E_W] || (r_e2[E_W-1:0] >= w_lim);
        n_d3.ctl.gir   = (w_lhs <= i_rhs);
        n_d3.ctl.remap = r_remap2;
        n_d3.rem       = r_e2[E_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_p1     <= n_p1;
            r_remap1 <= i_remap;
        end
        if (w_en2) begin
            r_e2     <= n_e2;
            r_l2     <= n_l2;
            r_remap2 <= r_remap1;
        end
        if (w_en3) begin
            r_d3 <= n_d3;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_d3;

endmodule

// File: sv/gri_div.sv
// Pipelined restoring divider: integer then fraction quotient bits, one per stage.
// Depends on gri_pkg.
module gri_div import gri_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_div_in         i_data,
    input  logic [SP_W-1:0] i_old_sp,
    output logic            o_valid,
    input  logic            i_stall,
    output t_div_out        o_data
);

    logic [DIV_ST-1:0] r_vld;
    logic [DIV_ST:0]   w_en;
    logic [E_W-1:0]    r_rem [DIV_ST];
    logic [QUO_W-1:0]  r_quo [DIV_ST];
    t_ctl              r_ctl [DIV_ST];

    assign w_en[DIV_ST] = !i_stall;
    assign o_stall      = !w_en[0];

    for (genvar k = 0; k < DIV_ST; k++) begin : g_st
        logic             w_vld_in;
        logic [E_W-1:0]   w_rem_in;
        logic [QUO_W-1:0] w_quo_in;
        t_ctl             w_ctl_in;
        logic [E_W-1:0]   w_rem_sh;
        logic [E_W-1:0]   w_dv;
        logic [E_W:0]     w_diff;
        logic             w_bit;

        if (k == 0) begin : g_first
            assign w_vld_in = i_valid;
            assign w_rem_in = i_data.rem;
            assign w_quo_in = '0;
            assign w_ctl_in = i_data.ctl;
        end else begin : g_next
            assign w_vld_in = r_vld[k-1];
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_ctl_in = r_ctl[k-1];
        end

        if (k < IDX_W) begin : g_int
            assign w_rem_sh = w_rem_in;
            assign w_dv     = E_W'(i_old_sp) << (IDX_W - 1 - k);
        end else begin : g_frac
            assign w_rem_sh = {w_rem_in[E_W-2:0], 1'b0};
            assign w_dv     = E_W'(i_old_sp);
        end

        assign w_diff  = {1'b0, w_rem_sh} - {1'b0, w_dv};
        assign w_bit   = !w_diff[E_W];
        assign w_en[k] = !r_vld[k] || w_en[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_rem[k] <= w_bit ? w_diff[E_W-1:0] : w_rem_sh;
                r_quo[k] <= {w_quo_in[QUO_W-2:0], w_bit};
                r_ctl[k] <= w_ctl_in;
            end
        end
    end

    assign o_valid = r_vld[DIV_ST-1];

    always_comb begin
        o_data.ctl = r_ctl[DIV_ST-1];
        o_data.quo = r_quo[DIV_ST-1];
    end

endmodule

// File: sv/gri_back.sv
// Output stage: gate index range checks, weights and the output register.
// Depends on gri_pkg.
module gri_back import gri_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_div_out                 i_data,
    input  logic [CNT_W-1:0]         i_count,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_remap_needed,
    output logic                     o_gate_in_range,
    output logic signed [GATE_W-1:0] o_nearest_gate,
    output logic signed [GATE_W-1:0] o_lower_gate,
    output logic signed [GATE_W-1:0] o_upper_gate,
    output logic [WT_W-1:0]          o_lower_weight,
    output logic [WT_W-1:0]          o_upper_weight
);

    logic r_vld;
    logic w_en;

    logic                     r_remap;
    logic                     r_gir;
    logic signed [GATE_W-1:0] r_nearest;
    logic signed [GATE_W-1:0] r_lower;
    logic signed [GATE_W-1:0] r_upper;
    logic [WT_W-1:0]          r_lw;
    logic [WT_W-1:0]          r_uw;

    // quotient integer part is lower gate + 1
    logic [IDX_W-1:0]  w_qe;
    logic [FRAC_W-1:0] w_frac;
    logic [IDX_W:0]    w_qe_x;
    logic [IDX_W:0]    w_cnt_x;
    logic [IDX_W:0]    w_nq;
    logic              w_lv, w_uv, w_nv;
    logic [IDX_W-1:0]  w_lower_idx;
    logic [IDX_W:0]    w_near_idx;

    logic signed [GATE_W-1:0] n_nearest;
    logic signed [GATE_W-1:0] n_lower;
    logic signed [GATE_W-1:0] n_upper;
    logic [WT_W-1:0]          n_lw;
    logic [WT_W-1:0]          n_uw;

    assign w_en    = !r_vld || !i_stall;
    assign o_stall = !w_en;

    assign w_qe    = i_data.quo[QUO_W-1:FRAC_W];
    assign w_frac  = i_data.quo[FRAC_W-1:0];
    assign w_qe_x  = {1'b0, w_qe};
    assign w_cnt_x = (IDX_W + 1)'(i_count);
    assign w_nq    = w_qe_x + (IDX_W + 1)'(w_frac[FRAC_W-1]);

    assign w_lv = !i_data.ctl.far && (w_qe != '0) && (w_qe_x <= w_cnt_x);
    assign w_uv = !i_data.ctl.far && (w_qe_x < w_cnt_x);
    assign w_nv = !i_data.ctl.far && (w_nq != '0) && (w_nq <= w_cnt_x);

    assign w_lower_idx = w_qe - IDX_W'(1);
    assign w_near_idx  = w_nq - (IDX_W + 1)'(1);

    always_comb begin
        n_lower   = w_lv ? $signed(GATE_W'(w_lower_idx)) : '1;
        n_upper   = w_uv ? $signed(GATE_W'(w_qe)) : '1;
        n_nearest = w_nv ? $signed(w_near_idx[GATE_W-1:0]) : '1;
        if (w_lv && w_uv) begin
            n_uw = {1'b0, w_frac};
            n_lw = {1'b1, {FRAC_W{1'b0}}} - {1'b0, w_frac};
        end else begin
            n_uw = '0;
            n_lw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_remap   <= i_data.ctl.remap;
            r_gir     <= i_data.ctl.gir;
            r_nearest <= n_nearest;
            r_lower   <= n_lower;
            r_upper   <= n_upper;
            r_lw      <= n_lw;
            r_uw      <= n_uw;
        end
    end

    assign o_valid         = r_vld;
    assign o_remap_needed  = r_remap;
    assign o_gate_in_range = r_gir;
    assign o_nearest_gate  = r_nearest;
    assign o_lower_gate    = r_lower;
    assign o_upper_gate    = r_upper;
    assign o_lower_weight  = r_lw;
    assign o_upper_weight  = r_uw;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for gate_resample_index_weight: directed and random target gates over many
// geometries, each result checked against a resampling predictor kept in the bench.
// Depends on gri_pkg and the gate_resample_index_weight RTL.
module tb;
    import gri_pkg::*;

    typedef struct packed {
        logic                     remap;
        logic                     in_range;
        logic signed [GATE_W-1:0] nearest;
        logic signed [GATE_W-1:0] lower;
        logic signed [GATE_W-1:0] upper;
        logic [WT_W-1:0]          lower_wt;
        logic [WT_W-1:0]          upper_wt;
    } t_resample;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx     = '0;
    logic [CFG_W-1:0]         i_cfg_data    = '0;
    logic                     i_valid       = 1'b0;
    logic [TGT_W-1:0]         i_target_gate = '0;
    logic                     i_stall       = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic                     o_remap_needed;
    logic                     o_gate_in_range;
    logic signed [GATE_W-1:0] o_nearest_gate;
    logic signed [GATE_W-1:0] o_lower_gate;
    logic signed [GATE_W-1:0] o_upper_gate;
    logic [WT_W-1:0]          o_lower_weight;
    logic [WT_W-1:0]          o_upper_weight;

    // geometry as last written
    logic [CNT_W-1:0] geo_count     = '0;
    logic [RNG_W-1:0] geo_old_start = 32'd32768;
    logic [SP_W-1:0]  geo_old_sp    = 31'd65536;
    logic [RNG_W-1:0] geo_new_start = 32'd32768;
    logic [SP_W-1:0]  geo_new_sp    = 31'd65536;

    logic [TGT_W-1:0] target_queue[$];
    t_resample        resample_due[$];

    bit idle_on    = 1'b0;
    bit in_taken   = 1'b0;
    int src_gap    = 0;
    int dst_gap    = 0;
    int mismatches = 0;

    gate_resample_index_weight DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_target_gate   (i_target_gate),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_remap_needed  (o_remap_needed),
        .o_gate_in_range (o_gate_in_range),
        .o_nearest_gate  (o_nearest_gate),
        .o_lower_gate    (o_lower_gate),
        .o_upper_gate    (o_upper_gate),
        .o_lower_weight  (o_lower_weight),
        .o_upper_weight  (o_upper_weight)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint floor_div(input longint a, input longint b);
        if (a < 0 && (a % b) != 0) return a / b - 1;
        return a / b;
    endfunction

    function automatic logic [GATE_W-1:0] old_gate_or_none(input longint g, input longint n);
        return (g < 0 || g > n - 1) ? '1 : GATE_W'(g);
    endfunction

    function automatic t_resample predict_resample(input logic [TGT_W-1:0] tgt);
        longint    s_old, s_new, sp_old, sp_new, cnt, tg;
        longint    span, new_cnt, offset, quo, lo, hi, near, frac;
        t_resample r;
        s_old  = $signed(geo_old_start);
        s_new  = $signed(geo_new_start);
        sp_old = geo_old_sp;
        sp_new = geo_new_sp;
        cnt    = geo_count;
        tg     = tgt;
        if (sp_old == 0) sp_old = 1;
        if (sp_new == 0) sp_new = 1;
        if (cnt > MAX_GATES) cnt = MAX_GATES;

        r.remap = !(s_old == s_new && geo_old_sp == geo_new_sp);

        span       = s_old + cnt * sp_old - s_new;
        new_cnt    = floor_div(2 * span + sp_new, 2 * sp_new);
        r.in_range = tg < new_cnt;

        offset = s_new + tg * sp_new - s_old;
        quo    = floor_div(offset * 65536, sp_old);
        lo     = floor_div(quo, 65536);
        near   = floor_div(quo + 32768, 65536);
        hi     = lo + 1;
        frac   = quo - lo * 65536;

        r.nearest = old_gate_or_none(near, cnt);
        r.lower   = old_gate_or_none(lo, cnt);
        r.upper   = old_gate_or_none(hi, cnt);
        if (lo >= 0 && lo <= cnt - 1 && hi >= 0 && hi <= cnt - 1) begin
            r.lower_wt = WT_W'(65536 - frac);
            r.upper_wt = WT_W'(frac);
        end else begin
            r.lower_wt = '0;
            r.upper_wt = '0;
        end
        return r;
    endfunction

    // source side: one transfer per accepted target, random gap bursts
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (target_queue.size() != 0) begin
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 16);
                    i_valid <= 1'b0;
                end else begin
                    i_valid       <= 1'b1;
                    i_target_gate <= target_queue.pop_front();
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // sink side stall bursts
    always @(negedge i_clk) begin
        if (dst_gap > 0) begin
            dst_gap--;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            dst_gap = $urandom_range(0, 16);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_resample got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.remap    = o_remap_needed;
            got.in_range = o_gate_in_range;
            got.nearest  = o_nearest_gate;
            got.lower    = o_lower_gate;
            got.upper    = o_upper_gate;
            got.lower_wt = o_lower_weight;
            got.upper_wt = o_upper_weight;
            if (resample_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transfer with nothing outstanding", $realtime);
            end else begin
                want = resample_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: mismatch want remap %0b rng %0b near %0d lo %0d up %0d",
                                  " lw %0d uw %0d / got remap %0b rng %0b near %0d lo %0d",
                                  " up %0d lw %0d uw %0d"}, $realtime,
                                 want.remap, want.in_range, want.nearest, want.lower,
                                 want.upper, want.lower_wt, want.upper_wt,
                                 got.remap, got.in_range, got.nearest, got.lower,
                                 got.upper, got.lower_wt, got.upper_wt);
                end
            end
        end
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            resample_due.insert(resample_due.size(), predict_resample(i_target_gate));
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [CNT_W-1:0] cnt, input logic [RNG_W-1:0] os,
                                input logic [SP_W-1:0] osp, input logic [RNG_W-1:0] ns,
                                input logic [SP_W-1:0] nsp);
        write_reg(CFG_OLD_COUNT, CFG_W'(cnt));
        write_reg(CFG_OLD_START, os);
        write_reg(CFG_OLD_SP, CFG_W'(osp));
        write_reg(CFG_NEW_START, ns);
        write_reg(CFG_NEW_SP, CFG_W'(nsp));
        i_cfg_we      <= 1'b0;
        geo_count     = cnt;
        geo_old_start = os;
        geo_old_sp    = osp;
        geo_new_start = ns;
        geo_new_sp    = nsp;
        // wait for the registered derived geometry terms to settle
        repeat (4) @(negedge i_clk);
    endtask

    // returns on a falling edge once every target is through and checked
    task automatic drain();
        #1;
        while (target_queue.size() != 0 || resample_due.size() != 0 || i_valid) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int     cnt_i, os_i, ns_i, osp_i, nsp_i, hi;
        longint reach;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: equal, no old gates
        target_queue = '{12'd0, 12'd4095, 12'd1};
        drain();
        // count above the cap, zero old spacing, extreme new start and spacing
        set_geometry(13'd8191, 32'd0, 31'd0, 32'h8000_0000, 31'h7FFF_FFFF);
        target_queue = '{12'd0, 12'd4095, 12'd2048};
        drain();
        set_geometry(13'd4096, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'd1);
        target_queue = '{12'd0, 12'd4095};
        drain();
        // half-gate offset; last gate has no upper neighbour
        set_geometry(13'd10, 32'd0, 31'd65536, 32'd32768, 31'd65536);
        target_queue = '{12'd0, 12'd1, 12'd8, 12'd9, 12'd10, 12'd4095};
        drain();
        // equal geometry with old gates present
        set_geometry(13'd10, 32'd65536, 31'd65536, 32'd65536, 31'd65536);
        target_queue = '{12'd3, 12'd9};
        drain();
        // new start beyond the old span: negative new gate count
        set_geometry(13'd5, 32'd0, 31'd65536, 32'h4000_0000, 31'd65536);
        target_queue = '{12'd0, 12'd3};
        drain();
        // new start before the old one: negative indices
        set_geometry(13'd100, 32'd655360, 31'd65536, 32'd0, 31'd32768);
        target_queue = '{12'd0, 12'd5, 12'd20, 12'd21};
        drain();

        for (int p = 0; p < 14; p++) begin
            idle_on = (p < 12) && (p % 4 != 3);
            if ($urandom_range(0, 1) == 0) begin
                osp_i = $urandom_range(4096, 262144);
                nsp_i = $urandom_range(osp_i / 4, osp_i * 4);
                os_i  = $urandom_range(0, 1 << 22);
                ns_i  = os_i + int'($urandom_range(0, 8 * osp_i)) - 4 * osp_i;
                cnt_i = $urandom_range(1, 4096);
            end else begin
                case ($urandom_range(0, 4))
                    0:       cnt_i = 0;
                    1:       cnt_i = 4096;
                    2:       cnt_i = 8191;
                    3:       cnt_i = $urandom_range(0, 8191);
                    default: cnt_i = $urandom_range(1, 4096);
                endcase
                case ($urandom_range(0, 4))
                    0:       osp_i = 0;
                    1:       osp_i = int'($urandom & 32'h7FFF_FFFF);
                    2:       osp_i = 32'h7FFF_FFFF;
                    default: osp_i = $urandom_range(1, 1 << 20);
                endcase
                case ($urandom_range(0, 4))
                    0:       nsp_i = 0;
                    1:       nsp_i = int'($urandom & 32'h7FFF_FFFF);
                    2:       nsp_i = 32'h7FFF_FFFF;
                    default: nsp_i = $urandom_range(1, 1 << 20);
                endcase
                case ($urandom_range(0, 3))
                    0:       os_i = int'($urandom);
                    1:       os_i = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    default: os_i = int'($urandom_range(0, 4 << 20)) - (2 << 20);
                endcase
                case ($urandom_range(0, 3))
                    0:       ns_i = int'($urandom);
                    1:       ns_i = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    default: ns_i = int'($urandom_range(0, 4 << 20)) - (2 << 20);
                endcase
            end
            if ($urandom_range(0, 4) == 0) begin
                ns_i  = os_i;
                nsp_i = osp_i;
            end
            set_geometry(CNT_W'(cnt_i), RNG_W'(os_i), SP_W'(osp_i), RNG_W'(ns_i),
                         SP_W'(nsp_i));

            // bias targets toward the covered part of the old span
            reach = longint'(cnt_i) * longint'(osp_i == 0 ? 1 : osp_i);
            reach = reach / longint'(nsp_i == 0 ? 1 : nsp_i) + 2;
            hi    = (reach > 4095) ? 4095 : int'(reach);
            for (int k = 0; k < 125; k++) begin
                if ($urandom_range(0, 3) != 0)
                    target_queue.insert(target_queue.size(), TGT_W'($urandom_range(0, hi)));
                else
                    target_queue.insert(target_queue.size(), TGT_W'($urandom_range(0, 4095)));
            end
            drain();
        end

        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && resample_due.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("tb failed");
        $finish;
    end

endmodule
